/* src/dtfe_pkg.sv */
// Shared types, codes and calendar helpers for the date and time field editor.
package dtfe_pkg;

  // Button command codes
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_INC    = 3'd1;
  localparam logic [2:0] OP_DEC    = 3'd2;
  localparam logic [2:0] OP_RIGHT  = 3'd3;
  localparam logic [2:0] OP_LEFT   = 3'd4;
  localparam logic [2:0] OP_TOGGLE = 3'd5;
  localparam logic [2:0] OP_SET    = 3'd6;
  localparam logic [2:0] OP_LOAD   = 3'd7;

  // Field selection codes
  localparam logic [2:0] F_DAY    = 3'd0;
  localparam logic [2:0] F_MONTH  = 3'd1;
  localparam logic [2:0] F_YEAR   = 3'd2;
  localparam logic [2:0] F_HOUR   = 3'd3;
  localparam logic [2:0] F_MINUTE = 3'd4;
  localparam logic [2:0] F_SECOND = 3'd5;

  // Commit kinds
  localparam logic [1:0] COMMIT_NONE = 2'd0;
  localparam logic [1:0] COMMIT_DATE = 2'd1;
  localparam logic [1:0] COMMIT_TIME = 2'd2;

  // Field limits
  localparam logic [3:0] MONTH_MAX = 4'd12;
  localparam logic [4:0] HOUR_MAX  = 5'd23;
  localparam logic [5:0] MIN_MAX   = 6'd59;

  // Edited date, time and selection
  typedef struct packed {
    logic [4:0] day;
    logic [3:0] month;
    logic [7:0] year;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       page;
    logic [2:0] field;
  } dtfe_state_t;

  // Values offered with a load command
  typedef struct packed {
    logic [4:0] day;
    logic [3:0] month;
    logic [7:0] year;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } dtfe_load_t;

  // Gregorian leap test on 2000 + offset; within 2000..2255 only 2100 and 2200
  // are multiples of four that fail it
  function automatic logic is_leap(input logic [7:0] off);
    is_leap = (off[1:0] == 2'd0) && (off != 8'd100) && (off != 8'd200);
  endfunction

  // Days in a month; an invalid month counts as January
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic [7:0] off);
    logic [4:0] len;
    case (m)
      4'd2:                      len = is_leap(off) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    month_len = len;
  endfunction

  // Day pulled into 1..len
  function automatic logic [4:0] clamp_day(input logic [4:0] d, input logic [4:0] len);
    logic [4:0] r;
    r = (d > len) ? len : d;
    if (r == 5'd0) r = 5'd1;
    clamp_day = r;
  endfunction

  // Step up with wrap from hi to lo
  function automatic logic [5:0] wrap_up(input logic [5:0] v, input logic [5:0] lo,
                                         input logic [5:0] hi);
    wrap_up = (v >= hi) ? lo : v + 6'd1;
  endfunction

  // Step down with wrap from lo (or out of range) to hi
  function automatic logic [5:0] wrap_down(input logic [5:0] v, input logic [5:0] lo,
                                           input logic [5:0] hi);
    wrap_down = ((v <= lo) || (v > hi)) ? hi : v - 6'd1;
  endfunction

endpackage

/* src/dtfe_next.sv */
// Next-state logic: applies one button command to the edited date and time.
module dtfe_next (
  input  dtfe_pkg::dtfe_state_t cur_i,
  input  logic [2:0]            opcode_i,
  input  dtfe_pkg::dtfe_load_t  load_i,
  output dtfe_pkg::dtfe_state_t nxt_o,
  output logic [1:0]            commit_o
);

  logic [2:0] base;
  logic       in_page;
  logic       up;
  logic [3:0] ld_month;
  logic [5:0] month_step;
  logic [5:0] hour_step;
  logic [3:0] new_month;
  logic [7:0] new_year;

  always_comb begin
    base       = cur_i.page ? dtfe_pkg::F_HOUR : dtfe_pkg::F_DAY;
    in_page    = (cur_i.field >= base) && (cur_i.field <= base + 3'd2);
    up         = (opcode_i == dtfe_pkg::OP_INC);
    month_step = up ? dtfe_pkg::wrap_up({2'd0, cur_i.month}, 6'd1,
                                        {2'd0, dtfe_pkg::MONTH_MAX})
                    : dtfe_pkg::wrap_down({2'd0, cur_i.month}, 6'd1,
                                          {2'd0, dtfe_pkg::MONTH_MAX});
    new_month  = month_step[3:0];
    hour_step  = up ? dtfe_pkg::wrap_up({1'b0, cur_i.hour}, 6'd0,
                                        {1'b0, dtfe_pkg::HOUR_MAX})
                    : dtfe_pkg::wrap_down({1'b0, cur_i.hour}, 6'd0,
                                          {1'b0, dtfe_pkg::HOUR_MAX});
    new_year   = up ? cur_i.year + 8'd1 : cur_i.year - 8'd1;
    // Saturate loaded month into 1..12
    if (load_i.month == 4'd0)                 ld_month = 4'd1;
    else if (load_i.month > dtfe_pkg::MONTH_MAX) ld_month = dtfe_pkg::MONTH_MAX;
    else                                      ld_month = load_i.month;

    nxt_o    = cur_i;
    commit_o = dtfe_pkg::COMMIT_NONE;

    case (opcode_i)
      dtfe_pkg::OP_INC, dtfe_pkg::OP_DEC: begin
        case (cur_i.field)
          dtfe_pkg::F_DAY: begin
            if (up) begin
              nxt_o.day = (cur_i.day >= dtfe_pkg::month_len(cur_i.month, cur_i.year))
                          ? 5'd1 : cur_i.day + 5'd1;
            end else begin
              nxt_o.day = ((cur_i.day <= 5'd1) ||
                           (cur_i.day > dtfe_pkg::month_len(cur_i.month, cur_i.year)))
                          ? dtfe_pkg::month_len(cur_i.month, cur_i.year)
                          : cur_i.day - 5'd1;
            end
          end
          dtfe_pkg::F_MONTH: begin
            nxt_o.month = new_month;
            nxt_o.day   = dtfe_pkg::clamp_day(cur_i.day,
                                              dtfe_pkg::month_len(new_month, cur_i.year));
          end
          dtfe_pkg::F_YEAR: begin
            nxt_o.year = new_year;
            nxt_o.day  = dtfe_pkg::clamp_day(cur_i.day,
                                             dtfe_pkg::month_len(cur_i.month, new_year));
          end
          dtfe_pkg::F_HOUR: begin
            nxt_o.hour = hour_step[4:0];
          end
          dtfe_pkg::F_MINUTE: begin
            nxt_o.minute = up ? dtfe_pkg::wrap_up(cur_i.minute, 6'd0, dtfe_pkg::MIN_MAX)
                              : dtfe_pkg::wrap_down(cur_i.minute, 6'd0, dtfe_pkg::MIN_MAX);
          end
          dtfe_pkg::F_SECOND: begin
            nxt_o.second = up ? dtfe_pkg::wrap_up(cur_i.second, 6'd0, dtfe_pkg::MIN_MAX)
                              : dtfe_pkg::wrap_down(cur_i.second, 6'd0, dtfe_pkg::MIN_MAX);
          end
          default: begin
            nxt_o.field = cur_i.field;
          end
        endcase
      end
      dtfe_pkg::OP_RIGHT: begin
        nxt_o.field = (!in_page || (cur_i.field == base + 3'd2)) ? base
                                                                : cur_i.field + 3'd1;
      end
      dtfe_pkg::OP_LEFT: begin
        if (!in_page)                nxt_o.field = base;
        else if (cur_i.field == base) nxt_o.field = base + 3'd2;
        else                          nxt_o.field = cur_i.field - 3'd1;
      end
      dtfe_pkg::OP_TOGGLE: begin
        nxt_o.page  = ~cur_i.page;
        nxt_o.field = cur_i.page ? dtfe_pkg::F_DAY : dtfe_pkg::F_HOUR;
      end
      dtfe_pkg::OP_SET: begin
        commit_o = cur_i.page ? dtfe_pkg::COMMIT_TIME : dtfe_pkg::COMMIT_DATE;
      end
      dtfe_pkg::OP_LOAD: begin
        nxt_o.year   = load_i.year;
        nxt_o.month  = ld_month;
        nxt_o.day    = dtfe_pkg::clamp_day(load_i.day,
                                           dtfe_pkg::month_len(ld_month, load_i.year));
        nxt_o.hour   = (load_i.hour > dtfe_pkg::HOUR_MAX) ? dtfe_pkg::HOUR_MAX : load_i.hour;
        nxt_o.minute = (load_i.minute > dtfe_pkg::MIN_MAX) ? dtfe_pkg::MIN_MAX
                                                           : load_i.minute;
        nxt_o.second = (load_i.second > dtfe_pkg::MIN_MAX) ? dtfe_pkg::MIN_MAX
                                                           : load_i.second;
      end
      default: begin
        commit_o = dtfe_pkg::COMMIT_NONE;
      end
    endcase
  end

endmodule

/* src/date_time_field_editor.sv */
// Top level of the date and time field editor: state register, handshake and result.
//
//  channel  | dir | tdata                                   | tuser
//  s_axis   | in  | load day/month/year/hour/minute/second  | opcode
//  m_axis   | out | edited values, page, field, cursor      | commit kind
//
// One command per cycle while s_axis_tready_o is high; each accepted transaction
// gives one result in the next cycle. The state register doubles as the result register.
// A result held by m_axis_tready low still lets the next command in the cycle it leaves.
// Reset: date 01, January, offset 0, time 00:00:00, date page, day selected.
module date_time_field_editor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [4:0] load_day, [8:5] load_month, [16:9] load_year, [21:17] load_hour,
  // [27:22] load_minute, [33:28] load_second, [39:34] zero
  input  logic [39:0] s_axis_tdata_i,
  // [2:0] opcode
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [4:0] day_out, [8:5] month_out, [16:9] year_out, [21:17] hour_out,
  // [27:22] minute_out, [33:28] second_out, [34] page_out, [37:35] field_out,
  // [40:38] cursor_offset, [47:41] zero
  output logic [47:0] m_axis_tdata_o,
  // [1:0] commit_kind
  output logic [1:0]  m_axis_tuser_o
);

  dtfe_pkg::dtfe_state_t state_q, state_d;
  dtfe_pkg::dtfe_load_t  load;
  logic [1:0]            commit_q, commit_d;
  logic                  out_valid_q, out_valid_d;
  logic                  s_accept;
  logic [2:0]            base;
  logic [2:0]            rel_field;

  // Handshake: take a command when the result slot is empty or being drained
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  // Unpack load values
  assign load.day    = s_axis_tdata_i[4:0];
  assign load.month  = s_axis_tdata_i[8:5];
  assign load.year   = s_axis_tdata_i[16:9];
  assign load.hour   = s_axis_tdata_i[21:17];
  assign load.minute = s_axis_tdata_i[27:22];
  assign load.second = s_axis_tdata_i[33:28];

  dtfe_next u_next (
    .cur_i    (state_q),
    .opcode_i (s_axis_tuser_i),
    .load_i   (load),
    .nxt_o    (state_d),
    .commit_o (commit_d)
  );

  // Output valid flag
  always_comb begin
    if (s_accept)             out_valid_d = 1'b1;
    else if (m_axis_tready_i) out_valid_d = 1'b0;
    else                      out_valid_d = out_valid_q;
  end

  // State and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q    <= 1'b0;
      commit_q       <= dtfe_pkg::COMMIT_NONE;
      state_q.day    <= 5'd1;
      state_q.month  <= 4'd1;
      state_q.year   <= 8'd0;
      state_q.hour   <= 5'd0;
      state_q.minute <= 6'd0;
      state_q.second <= 6'd0;
      state_q.page   <= 1'b0;
      state_q.field  <= dtfe_pkg::F_DAY;
    end else begin
      out_valid_q <= out_valid_d;
      if (s_accept) begin
        state_q  <= state_d;
        commit_q <= commit_d;
      end
    end
  end

  // Cursor position within the page, two columns per field
  assign base      = state_q.page ? dtfe_pkg::F_HOUR : dtfe_pkg::F_DAY;
  assign rel_field = state_q.field - base;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = commit_q;
  assign m_axis_tdata_o  = {7'd0, rel_field[1:0], 1'b0, state_q.field, state_q.page,
                            state_q.second, state_q.minute, state_q.hour,
                            state_q.year, state_q.month, state_q.day};

  // Day always lies within the current month
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.day >= 5'd1) &&
    (state_q.day <= dtfe_pkg::month_len(state_q.month, state_q.year)))
    else $error("day outside month length");

  // Edited values only move on an accepted transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_accept |=> $stable(state_q) && $stable(commit_q))
    else $error("state changed without a transaction");

  // A set command reports a commit kind matching the page
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && (s_axis_tuser_i == dtfe_pkg::OP_SET) |=>
      (commit_q == (state_q.page ? dtfe_pkg::COMMIT_TIME : dtfe_pkg::COMMIT_DATE)))
    else $error("commit kind does not match page");

  // Toggling the page puts the cursor on the first field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && (s_axis_tuser_i == dtfe_pkg::OP_TOGGLE) |=> (rel_field == 3'd0))
    else $error("page toggle left cursor off first field");

endmodule
